@@ rtl/lprb_pkg.sv @@
// lprb_pkg: shared constants, codes and payload types of the
// length-prefixed ring buffer. No dependencies.
`default_nettype none

package lprb_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int MAX_MESSAGE = 255;

  localparam int PTR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int MSG_W = 8;
  localparam int CAP_W = 9;
  localparam int FREE_W = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_NO_ROOM = 3'd2,
    ST_DROPPED = 3'd3,
    ST_NO_OPEN = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]       command;
    logic             first_of_message;
    logic [MSG_W-1:0] msg_length;
    logic [7:0]       data_byte;
  } req_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic [MSG_W-1:0]  read_length;
    logic              read_first;
    logic              read_last;
    logic [2:0]        status;
    logic [FREE_W-1:0] free_bytes;
    logic              is_empty;
    logic              is_full;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/lprb_ram.sv @@
// lprb_ram: generic single-write, single-read memory with registered read.
// A read at the address being written returns the old contents.
`default_nettype none

module lprb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/length_prefixed_ring_buffer.sv @@
// length_prefixed_ring_buffer: top level of the message ring store.
// Depends on lprb_pkg and two lprb_ram instances (length bytes, data bytes).
`default_nettype none

// Byte ring store for variable-length messages. A write request whose first
// flag is set opens a message: its length byte and first data byte are stored
// together, and the whole message is refused unless length+1 bytes are free;
// the rest of a refused message is dropped. Each read request pops one byte of
// the oldest message (the first read also pops its length). Clear and a write
// of capacity_bytes empty the store. Requests are taken one per cycle while
// req_stall is low, and each gives one response: the request waits in the
// request register while the memory read for it completes, then the result
// moves to the response register. Length bytes and data bytes sit in two
// separate memories at their ring positions, so the two-byte first write and
// first read each need only one port per memory; reads are issued ahead from
// the next pointer state, with a bypass for a byte written in the same cycle.
module length_prefixed_ring_buffer
  import lprb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire req_t             req,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output rsp_t                  rsp,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_data
);

  typedef struct packed {
    logic [PTR_W-1:0] wp;
    logic [PTR_W-1:0] rp;
    logic             full;
    logic [MSG_W-1:0] wleft;
    logic             wdrop;
    logic [MSG_W-1:0] rleft;
  } ring_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] s;
    s = CNT_W'(p) + CNT_W'(1);
    return (s >= cap) ? '0 : PTR_W'(s);
  endfunction

  function automatic logic [CNT_W-1:0] free_of(input ring_t r,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] f;
    if (r.full) begin
      f = '0;
    end else if (r.wp < r.rp) begin
      f = CNT_W'(r.rp) - CNT_W'(r.wp);
    end else begin
      f = cap + CNT_W'(r.rp) - CNT_W'(r.wp);
    end
    return f;
  endfunction

  ring_t            ring;
  ring_t            ring_next;
  logic [CAP_W-1:0] cap_reg;
  logic [CNT_W-1:0] cap_eff;

  logic             s_valid;
  req_t             s_req;
  logic             o_valid;
  rsp_t             o_rsp;
  rsp_t             rsp_next;
  logic             fire;

  logic             len_we_raw;
  logic             dat_we_raw;
  logic             len_we;
  logic             dat_we;
  logic [PTR_W-1:0] len_waddr;
  logic [PTR_W-1:0] dat_waddr;
  logic [PTR_W-1:0] len_raddr;
  logic [PTR_W-1:0] dat_raddr;
  logic [7:0]       len_q;
  logic [7:0]       dat_q;
  logic             len_hit;
  logic             dat_hit;
  logic [7:0]       len_byp;
  logic [7:0]       dat_byp;
  logic [7:0]       len_rd;
  logic [7:0]       dat_rd;

  logic [PTR_W-1:0] up_rp;
  logic [MSG_W-1:0] up_rleft;
  logic [PTR_W-1:0] p1;
  logic [PTR_W-1:0] p2;
  logic [CNT_W-1:0] free_cur;
  logic [CNT_W-1:0] stored;

  assign cfg_ready = 1'b1;
  assign fire      = s_valid && (!o_valid || !rsp_stall);
  assign req_stall = s_valid && !fire;
  assign rsp_valid = o_valid;
  assign rsp       = o_rsp;

  always_comb begin
    if (cap_reg < CAP_W'(2)) begin
      cap_eff = CNT_W'(2);
    end else if (int'(cap_reg) > STORE_DEPTH) begin
      cap_eff = CNT_W'(STORE_DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_reg);
    end
  end

  assign free_cur = free_of(ring, cap_eff);
  assign stored   = cap_eff - free_cur;
  assign len_rd   = len_hit ? len_byp : len_q;
  assign dat_rd   = dat_hit ? dat_byp : dat_q;

  // one request against the current ring state
  always_comb begin
    ring_next  = ring;
    rsp_next   = '0;
    len_we_raw = 1'b0;
    dat_we_raw = 1'b0;
    len_waddr  = ring.wp;
    dat_waddr  = ring.wp;
    p1         = ptr_inc(ring.wp, cap_eff);
    p2         = ptr_inc(p1, cap_eff);
    case (s_req.command)
      CMD_WRITE: begin
        p1 = ptr_inc(ring.wp, cap_eff);
        p2 = ptr_inc(p1, cap_eff);
        if (ring.wdrop) begin
          rsp_next.status = ST_DROPPED;
          if (ring.wleft != '0) begin
            ring_next.wleft = ring.wleft - MSG_W'(1);
          end
          if (ring_next.wleft == '0) begin
            ring_next.wdrop = 1'b0;
          end
        end else if (ring.wleft != '0) begin
          dat_we_raw      = 1'b1;
          dat_waddr       = ring.wp;
          ring_next.wp    = p1;
          ring_next.full  = (p1 == ring.rp);
          ring_next.wleft = ring.wleft - MSG_W'(1);
        end else if (!s_req.first_of_message) begin
          rsp_next.status = ST_NO_OPEN;
        end else if (int'(s_req.msg_length) > MAX_MESSAGE
                     || int'(free_cur) < int'(s_req.msg_length) + 1) begin
          rsp_next.status = ST_NO_ROOM;
          if (s_req.msg_length > MSG_W'(1)) begin
            ring_next.wdrop = 1'b1;
            ring_next.wleft = s_req.msg_length - MSG_W'(1);
          end
        end else begin
          len_we_raw = 1'b1;
          len_waddr  = ring.wp;
          if (s_req.msg_length != '0) begin
            dat_we_raw      = 1'b1;
            dat_waddr       = p1;
            ring_next.wp    = p2;
            ring_next.full  = (p2 == ring.rp);
            ring_next.wleft = s_req.msg_length - MSG_W'(1);
          end else begin
            ring_next.wp   = p1;
            ring_next.full = (p1 == ring.rp);
          end
        end
      end
      CMD_READ: begin
        p1 = ptr_inc(ring.rp, cap_eff);
        p2 = ptr_inc(p1, cap_eff);
        if (!ring.full && ring.wp == ring.rp) begin
          rsp_next.status = ST_EMPTY;
        end else if (ring.rleft == '0) begin
          // the data byte of a non-empty message must already be stored
          if (len_rd != '0 && stored < CNT_W'(2)) begin
            rsp_next.status = ST_EMPTY;
          end else begin
            rsp_next.read_first  = 1'b1;
            rsp_next.read_length = len_rd;
            ring_next.full       = 1'b0;
            if (len_rd != '0) begin
              rsp_next.out_byte = dat_rd;
              ring_next.rp      = p2;
              ring_next.rleft   = len_rd - MSG_W'(1);
            end else begin
              ring_next.rp = p1;
            end
            rsp_next.read_last = (ring_next.rleft == '0);
          end
        end else begin
          rsp_next.out_byte  = dat_rd;
          ring_next.rp       = p1;
          ring_next.full     = 1'b0;
          ring_next.rleft    = ring.rleft - MSG_W'(1);
          rsp_next.read_last = (ring_next.rleft == '0);
        end
      end
      CMD_CLEAR: begin
        ring_next = '0;
      end
      default: begin
      end
    endcase
    rsp_next.free_bytes = FREE_W'(free_of(ring_next, cap_eff));
    rsp_next.is_empty   = !ring_next.full && (ring_next.wp == ring_next.rp);
    rsp_next.is_full    = ring_next.full;
  end

  assign len_we = len_we_raw && fire && !cfg_valid && !rst;
  assign dat_we = dat_we_raw && fire && !cfg_valid && !rst;

  // reads are issued from the state the next request will see
  always_comb begin
    if (rst || cfg_valid) begin
      up_rp    = '0;
      up_rleft = '0;
    end else if (fire) begin
      up_rp    = ring_next.rp;
      up_rleft = ring_next.rleft;
    end else begin
      up_rp    = ring.rp;
      up_rleft = ring.rleft;
    end
    len_raddr = up_rp;
    dat_raddr = (up_rleft == '0) ? ptr_inc(up_rp, cap_eff) : up_rp;
  end

  lprb_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_len_ram (
    .clk  (clk),
    .we   (len_we),
    .waddr(len_waddr),
    .wdata(s_req.msg_length),
    .raddr(len_raddr),
    .rdata(len_q)
  );

  lprb_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_dat_ram (
    .clk  (clk),
    .we   (dat_we),
    .waddr(dat_waddr),
    .wdata(s_req.data_byte),
    .raddr(dat_raddr),
    .rdata(dat_q)
  );

  always_ff @(posedge clk) begin
    len_byp <= s_req.msg_length;
    dat_byp <= s_req.data_byte;
    if (rst) begin
      len_hit <= 1'b0;
      dat_hit <= 1'b0;
    end else begin
      len_hit <= len_we && (len_waddr == len_raddr);
      dat_hit <= dat_we && (dat_waddr == dat_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring    <= '0;
      cap_reg <= CAP_RESET;
    end else if (cfg_valid) begin
      ring    <= '0;
      cap_reg <= cfg_data;
    end else if (fire) begin
      ring <= ring_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        s_valid <= 1'b1;
      end else if (fire) begin
        s_valid <= 1'b0;
      end
      if (fire) begin
        o_valid <= 1'b1;
      end else if (!rsp_stall) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s_req <= req;
    end
    if (fire) begin
      o_rsp <= rsp_next;
    end
  end

  a_full_ptrs: assert property (@(posedge clk) disable iff (rst)
    ring.full |-> ring.wp == ring.rp)
    else $error("full flag set with pointers apart");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(ring.wp) < cap_eff && CNT_W'(ring.rp) < cap_eff)
    else $error("pointer beyond capacity");

  a_drop_count: assert property (@(posedge clk) disable iff (rst)
    ring.wdrop |-> ring.wleft != '0)
    else $error("dropping with no bytes left");

  a_fire_rsp: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("processed request gave no response");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> ring.wp == '0 && ring.rp == '0 && !ring.full && ring.rleft == '0)
    else $error("capacity write did not clear the store");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking testbench for length_prefixed_ring_buffer.
// Depends on lprb_pkg and the rtl top; predicts each response in a small
// scoreboard class; tasks drive requests and capacity writes, a loop the stalls.
`timescale 1ns / 100ps

module tb_top;
  import lprb_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 80;

  // scoreboard: keeps its own copy of the ring and the capacity register
  class msg_ring_checker;
    logic [7:0] ring_bytes [STORE_DEPTH];
    int unsigned wr_ptr, rd_ptr, wr_left, rd_left;
    bit full, dropping;
    logic [CAP_W-1:0] cap_reg;
    rsp_t replies_due[$];
    int errors;
    int checked;

    function new();
      foreach (ring_bytes[i]) ring_bytes[i] = 8'd0;
      cap_reg = CAP_RESET;
      errors = 0;
      checked = 0;
      clear_ring();
    endfunction

    function void clear_ring();
      wr_ptr = 0;
      rd_ptr = 0;
      full = 1'b0;
      wr_left = 0;
      dropping = 1'b0;
      rd_left = 0;
    endfunction

    function void configure(logic [CAP_W-1:0] v);
      cap_reg = v;
      clear_ring();
    endfunction

    function int unsigned cap_eff();
      int unsigned c;
      c = 32'(cap_reg);
      if (c < 2) c = 2;
      if (c > STORE_DEPTH) c = STORE_DEPTH;
      return c;
    endfunction

    function int unsigned free_count();
      if (full) return 0;
      if (wr_ptr < rd_ptr) return rd_ptr - wr_ptr;
      return cap_eff() + rd_ptr - wr_ptr;
    endfunction

    function bit ring_empty();
      return !full && wr_ptr == rd_ptr;
    endfunction

    function void push_byte(logic [7:0] v);
      ring_bytes[wr_ptr[PTR_W-1:0]] = v;
      wr_ptr++;
      if (wr_ptr >= cap_eff()) wr_ptr = 0;
      full = (wr_ptr == rd_ptr);
    endfunction

    function logic [7:0] pop_byte();
      logic [7:0] v;
      v = ring_bytes[rd_ptr[PTR_W-1:0]];
      full = 1'b0;
      rd_ptr++;
      if (rd_ptr >= cap_eff()) rd_ptr = 0;
      return v;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // works out the response of one accepted request
    function void take_request(req_t r);
      rsp_t want;
      status_t st;
      logic [7:0] mlen;
      int unsigned stored;
      want = '0;
      st = ST_OK;
      case (r.command)
        CMD_WRITE: begin
          if (dropping) begin
            st = ST_DROPPED;
            if (wr_left > 0) wr_left--;
            if (wr_left == 0) dropping = 1'b0;
          end else if (wr_left > 0) begin
            push_byte(r.data_byte);
            wr_left--;
          end else if (!r.first_of_message) begin
            st = ST_NO_OPEN;
          end else if (int'(r.msg_length) > MAX_MESSAGE ||
                       free_count() < int'(r.msg_length) + 1) begin
            st = ST_NO_ROOM;
            if (r.msg_length > 1) begin
              dropping = 1'b1;
              wr_left = r.msg_length - 1;
            end
          end else begin
            push_byte(r.msg_length);
            if (r.msg_length > 0) begin
              push_byte(r.data_byte);
              wr_left = r.msg_length - 1;
            end
          end
        end
        CMD_READ: begin
          if (ring_empty()) begin
            st = ST_EMPTY;
          end else if (rd_left == 0) begin
            mlen = ring_bytes[rd_ptr[PTR_W-1:0]];
            stored = cap_eff() - free_count();
            // first data byte of the message not stored yet
            if (mlen > 0 && stored < 2) begin
              st = ST_EMPTY;
            end else begin
              void'(pop_byte());
              want.read_first = 1'b1;
              want.read_length = mlen;
              if (mlen > 0) begin
                want.out_byte = pop_byte();
                rd_left = mlen - 1;
              end
              want.read_last = (rd_left == 0);
            end
          end else begin
            want.out_byte = pop_byte();
            rd_left--;
            want.read_last = (rd_left == 0);
          end
        end
        CMD_CLEAR: clear_ring();
        default: ;
      endcase
      want.status = st;
      want.free_bytes = FREE_W'(free_count());
      want.is_empty = ring_empty();
      want.is_full = full;
      replies_due.push_back(want);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_reply(rsp_t got);
      rsp_t want;
      string bad;
      bad = "";
      checked++;
      if (replies_due.size() == 0) begin
        report($sformatf("response %0d arrived with no request pending: %h", checked, got));
        return;
      end
      want = replies_due.pop_front();
      if (got.out_byte !== want.out_byte) bad = {bad, " out_byte"};
      if (got.read_length !== want.read_length) bad = {bad, " read_length"};
      if (got.read_first !== want.read_first) bad = {bad, " read_first"};
      if (got.read_last !== want.read_last) bad = {bad, " read_last"};
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.free_bytes !== want.free_bytes) bad = {bad, " free_bytes"};
      if (got.is_empty !== want.is_empty) bad = {bad, " is_empty"};
      if (got.is_full !== want.is_full) bad = {bad, " is_full"};
      if (bad != "")
        report($sformatf("response %0d:%s, expected %h got %h", checked, bad, want, got));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  msg_ring_checker sb = new();
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int hold_request = 0;
  int items_sent = 0;
  int cycle_count = 0;

  length_prefixed_ring_buffer dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[length_prefixed_ring_buffer] ERROR");
      $finish;
    end
  end

  function req_t mk(logic [1:0] c, logic f, logic [7:0] l, logic [7:0] d);
    req_t r;
    r.command = c;
    r.first_of_message = f;
    r.msg_length = l;
    r.data_byte = d;
    return r;
  endfunction

  function req_t rand_req(logic [1:0] c);
    return mk(c, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endfunction

  task send_req(req_t r);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    sb.take_request(r);
    if (r.command != CMD_UNUSED) items_sent++;
  endtask

  // lets every pending response come back, then lets the pipeline settle
  task drain_replies();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_capacity(logic [CAP_W-1:0] v);
    drain_replies();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.configure(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one message: header request then its data bytes, reads now and then in between
  task send_message(int len);
    send_req(mk(CMD_WRITE, 1'b1, 8'(len), 8'($urandom_range(0, 255))));
    for (int k = 1; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) send_req(rand_req(CMD_READ));
      send_req(mk(CMD_WRITE, $urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255))));
    end
  endtask

  task run_burst();
    int pick, len, lim, k;
    int unsigned cap;
    cap = sb.cap_eff();
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      k = $urandom_range(0, 31);
      lim = (cap < 24) ? cap + 1 : 24;
      if (k == 0) len = $urandom_range(0, 255);
      else if (k < 5) len = $urandom_range(0, lim);
      else len = $urandom_range(0, 8);
      send_message(len);
    end else if (pick < 85) begin
      k = $urandom_range(1, 12);
      repeat (k) send_req(rand_req(CMD_READ));
    end else if (pick < 88) begin
      send_req(rand_req(CMD_CLEAR));
    end else if (pick < 94) begin
      send_req(mk(CMD_WRITE, 1'b0, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255))));
    end else begin
      send_req(rand_req(CMD_UNUSED));
    end
  endtask

  // response side: random stall after each response, long hold-off on request
  initial begin : reply_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        sb.check_reply(rsp);
        stall_left = recv_calm ? 0 : $urandom_range(0, 16);
      end
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [CAP_W-1:0] caps [12];
    int phase_end;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    caps = '{9'd0, 9'd3, 9'd511, 9'd5, 9'd16, 9'd256, 9'd2, 9'd64, 9'd257, 9'd255,
             9'd0, 9'd0};
    caps[10] = CAP_W'($urandom_range(2, 256));
    caps[11] = CAP_W'($urandom_range(0, 511));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset capacity
    send_req(mk(CMD_READ, 1'b1, 8'hFF, 8'hFF));         // empty store
    send_req(mk(CMD_WRITE, 1'b0, 8'hFF, 8'hFF));        // no open message
    send_req(mk(CMD_UNUSED, 1'b1, 8'hFF, 8'hFF));
    send_req(mk(CMD_WRITE, 1'b1, 8'h00, 8'hAA));        // zero length message
    send_req(mk(CMD_READ, 1'b0, 8'h00, 8'h00));
    send_req(mk(CMD_WRITE, 1'b1, 8'h03, 8'h00));
    send_req(mk(CMD_WRITE, 1'b0, 8'h00, 8'hFF));
    send_req(mk(CMD_READ, 1'b0, 8'h00, 8'h00));
    send_req(mk(CMD_READ, 1'b0, 8'h00, 8'h00));
    send_req(mk(CMD_READ, 1'b0, 8'h00, 8'h00));         // byte not written yet
    send_req(mk(CMD_WRITE, 1'b1, 8'hFF, 8'h5A));        // first flag inside message
    send_req(mk(CMD_READ, 1'b0, 8'h00, 8'h00));
    send_req(mk(CMD_WRITE, 1'b1, 8'hFF, 8'h81));        // longest message
    send_req(mk(CMD_CLEAR, 1'b0, 8'h00, 8'h00));
    send_req(mk(CMD_READ, 1'b0, 8'h00, 8'h00));

    // smallest ring: fill, refuse, drop
    write_capacity(9'd1);
    send_req(mk(CMD_WRITE, 1'b1, 8'h01, 8'hC3));
    send_req(mk(CMD_WRITE, 1'b1, 8'h00, 8'h00));
    send_req(mk(CMD_WRITE, 1'b1, 8'h05, 8'h11));
    send_req(mk(CMD_WRITE, 1'b1, 8'h00, 8'h22));
    send_req(mk(CMD_WRITE, 1'b0, 8'h7F, 8'h33));
    send_req(mk(CMD_WRITE, 1'b1, 8'h80, 8'h44));
    send_req(mk(CMD_WRITE, 1'b0, 8'h01, 8'h55));
    send_req(mk(CMD_READ, 1'b0, 8'h00, 8'h00));
    send_req(mk(CMD_WRITE, 1'b0, 8'h00, 8'h66));

    for (int p = 0; p < 12; p++) begin
      write_capacity(caps[p]);
      send_calm = (p % 3 == 1);
      recv_calm = (p % 4 == 2);
      if (p == 5) begin
        // back pressure: sink holds off while requests keep coming
        send_calm = 1'b1;
        hold_request = 400;
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) run_burst();
    end

    drain_replies();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("[length_prefixed_ring_buffer] OK");
    else
      $display("[length_prefixed_ring_buffer] ERROR");
    $finish;
  end

endmodule
